// File: rtl/pir_pkg.sv
package pir_pkg;

    // trail depth and its index width
    localparam int TRAIL_LEN = 16;
    localparam int IDX_W     = (TRAIL_LEN > 1) ? $clog2(TRAIL_LEN) : 1;

    // field widths
    localparam int COORD_W = 24;
    localparam int PUSH_W  = 28;
    localparam int VEL_W   = 29;   // speed plus push, also a difference of two coordinates

    // serial arithmetic widths
    localparam int OPW    = 29;    // unsigned operand of the multiplier, root of the square root
    localparam int PRODW  = 2 * OPW;
    localparam int REMW   = OPW + 3;
    localparam int QW     = 17;    // quotients stay below 2^16 in every use
    localparam int SQ_CNT_W  = $clog2(OPW);
    localparam int DIV_CNT_W = $clog2(QW);

    // request kinds
    localparam logic [1:0] OP_NEIGHBOR = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_PLACE    = 2'd2;

    // register indexes
    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_LIMIT    = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_STRENGTH = 3'd4;

endpackage

// File: rtl/pir_mul.sv
module pir_mul import pir_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [OPW-1:0]   i_a,
    input  logic [OPW-1:0]   i_b,
    output logic             o_done,
    output logic [PRODW-1:0] o_prod
);

    logic             r_busy;
    logic             r_done;
    logic [PRODW-1:0] r_a;
    logic [OPW-1:0]   r_b;
    logic [PRODW-1:0] r_acc;

    // control: runs until the multiplier bits are used up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_b == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // shift and add, one multiplier bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= {{(PRODW-OPW){1'b0}}, i_a};
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[PRODW-2:0], 1'b0};
            r_b <= {1'b0, r_b[OPW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/pir_sqrt.sv
module pir_sqrt import pir_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [PRODW-1:0] i_n,
    output logic             o_done,
    output logic [OPW-1:0]   o_root
);

    logic                r_busy;
    logic                r_done;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic [PRODW-1:0]    r_n;
    logic [REMW-1:0]     r_rem;
    logic [OPW-1:0]      r_root;

    logic [REMW-1:0] rem2;
    logic [REMW-1:0] trial;
    logic            fits;

    // bring down two radicand bits and try the next root bit
    assign rem2  = {r_rem[REMW-3:0], r_n[PRODW-1:PRODW-2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign fits  = (rem2 >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one root bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= SQ_CNT_W'(OPW - 1);
        end else if (r_busy) begin
            r_n <= {r_n[PRODW-3:0], 2'b00};
            if (fits) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[OPW-2:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[OPW-2:0], 1'b0};
            end
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/pir_div.sv
module pir_div import pir_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [PRODW-1:0] i_num,
    input  logic [OPW-1:0]   i_den,
    output logic             o_done,
    output logic [QW-1:0]    o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PRODW-1:0]     r_rem;
    logic [PRODW-1:0]     r_dsh;
    logic [QW-1:0]        r_q;

    logic fits;

    assign fits = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // restoring division, one quotient bit a cycle, quotient known to fit QW bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {{(PRODW-OPW){1'b0}}, i_den} << (QW - 1);
            r_q   <= '0;
            r_cnt <= DIV_CNT_W'(QW - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[QW-2:0], fits};
            r_dsh <= {1'b0, r_dsh[PRODW-1:1]};
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// File: rtl/particle_integrator_with_repulsion_top.sv
// One 2-D particle in Q15.8 pixels. Requests: tuser 0 pushes the particle away from a
// neighbor at (x, y), tuser 1 steps it one tick and returns its position with a wrap flag,
// tuser 2 places it fresh at (x, y). One request is worked on at a time; a tick result
// waits in an output register while the next request is taken. The time a neighbor or a
// tick takes is set by the bit-serial multiplier, which stops once the multiplier bits
// are used up, the square root and the divider, which both kinds share; a tick also
// scans every trail point and may wait for a free output register. A neighbor at the
// same spot or out of range finishes after the square root; a tick not above the speed
// limit skips the scaling.
module particle_integrator_with_repulsion_top import pir_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // coord_x [23:0], coord_y [47:24]
    input  logic [1:0]  s_axis_tuser,   // op [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pos_x [23:0], pos_y [47:24]
    output logic [0:0]  m_axis_tuser    // wrapped [0]
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SQX  = 5'd1;
    localparam logic [4:0] S_SQY  = 5'd2;
    localparam logic [4:0] S_ROOT = 5'd3;
    localparam logic [4:0] S_FMUL = 5'd4;
    localparam logic [4:0] S_FDIV = 5'd5;
    localparam logic [4:0] S_PXM  = 5'd6;
    localparam logic [4:0] S_PXD  = 5'd7;
    localparam logic [4:0] S_PYM  = 5'd8;
    localparam logic [4:0] S_PYD  = 5'd9;
    localparam logic [4:0] S_VXM  = 5'd10;
    localparam logic [4:0] S_VXD  = 5'd11;
    localparam logic [4:0] S_VYM  = 5'd12;
    localparam logic [4:0] S_VYD  = 5'd13;
    localparam logic [4:0] S_MOVE = 5'd14;
    localparam logic [4:0] S_SCAN = 5'd15;
    localparam logic [4:0] S_EMIT = 5'd16;

    // configuration
    logic [11:0] r_width;
    logic [11:0] r_height;
    logic [15:0] r_limit;
    logic [19:0] r_radius;
    logic [15:0] r_strength;

    // particle state
    logic signed [COORD_W-1:0] r_place_x;
    logic signed [COORD_W-1:0] r_place_y;
    logic signed [COORD_W-1:0] r_speed_x;
    logic signed [COORD_W-1:0] r_speed_y;
    logic signed [PUSH_W-1:0]  r_push_x;
    logic signed [PUSH_W-1:0]  r_push_y;
    logic signed [COORD_W-1:0] r_trail_x [TRAIL_LEN];
    logic signed [COORD_W-1:0] r_trail_y [TRAIL_LEN];

    // sequencer
    logic [4:0]             r_state;
    logic [4:0]             n_state;
    logic                   r_kick;
    logic                   n_kick;
    logic                   r_tick;
    logic signed [VEL_W-1:0] r_ax;
    logic signed [VEL_W-1:0] r_ay;
    logic [PRODW-1:0]       r_sq;
    logic [OPW-1:0]         r_root;
    logic [QW-1:0]          r_f;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_inside;

    // output register
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic                      r_out_wrap;

    // shared serial units
    logic             mul_done;
    logic [PRODW-1:0] mul_prod;
    logic [OPW-1:0]   mul_a;
    logic [OPW-1:0]   mul_b;
    logic             sq_done;
    logic [OPW-1:0]   sq_root;
    logic             div_done;
    logic [QW-1:0]    div_quo;
    logic [OPW-1:0]   div_den;

    logic                      in_accept;
    logic                      out_free;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic [OPW-1:0]            abs_ax;
    logic [OPW-1:0]            abs_ay;
    logic [COORD_W-1:0]        w_px;
    logic [COORD_W-1:0]        h_px;
    logic [VEL_W-1:0]          q_ext;
    logic signed [VEL_W-1:0]   q_signed_x;
    logic signed [VEL_W-1:0]   q_signed_y;
    logic signed [PUSH_W:0]    push_sum_x;
    logic signed [PUSH_W:0]    push_sum_y;
    logic signed [COORD_W-1:0] new_sx;
    logic signed [COORD_W-1:0] new_sy;
    logic signed [COORD_W:0]   pos_sum_x;
    logic signed [COORD_W:0]   pos_sum_y;
    logic signed [COORD_W-1:0] new_px;
    logic signed [COORD_W-1:0] new_py;
    logic signed [COORD_W-1:0] tr_x;
    logic signed [COORD_W-1:0] tr_y;
    logic                      tr_inside;
    logic signed [COORD_W-1:0] wrap_px;
    logic signed [COORD_W-1:0] wrap_py;

    function automatic logic signed [COORD_W-1:0] sat_vel(input logic signed [VEL_W-1:0] v);
        if (v > VEL_W'($signed(COORD_W'(2**(COORD_W-1)-1)))) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v < -$signed(VEL_W'(2**(COORD_W-1)))) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [PUSH_W-1:0] sat_push(input logic signed [PUSH_W:0] v);
        if (v[PUSH_W] != v[PUSH_W-1]) begin
            return {v[PUSH_W], {(PUSH_W-1){~v[PUSH_W]}}};
        end
        return v[PUSH_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_pos(input logic signed [COORD_W:0] v);
        if (v[COORD_W] != v[COORD_W-1]) begin
            return {v[COORD_W], {(COORD_W-1){~v[COORD_W]}}};
        end
        return v[COORD_W-1:0];
    endfunction

    assign in_x      = s_axis_tdata[23:0];
    assign in_y      = s_axis_tdata[47:24];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    assign abs_ax = r_ax[VEL_W-1] ? OPW'(-r_ax) : OPW'(r_ax);
    assign abs_ay = r_ay[VEL_W-1] ? OPW'(-r_ay) : OPW'(r_ay);

    // screen extent in Q.8
    assign w_px = {{(COORD_W-20){1'b0}}, r_width, 8'd0};
    assign h_px = {{(COORD_W-20){1'b0}}, r_height, 8'd0};

    // signed quotient, sign taken from the component being scaled
    assign q_ext      = {{(VEL_W-QW){1'b0}}, div_quo};
    assign q_signed_x = r_ax[VEL_W-1] ? -$signed(q_ext) : $signed(q_ext);
    assign q_signed_y = r_ay[VEL_W-1] ? -$signed(q_ext) : $signed(q_ext);
    assign push_sum_x = {r_push_x[PUSH_W-1], r_push_x} + q_signed_x;
    assign push_sum_y = {r_push_y[PUSH_W-1], r_push_y} + q_signed_y;

    // integration step
    assign new_sx    = sat_vel(r_ax);
    assign new_sy    = sat_vel(r_ay);
    assign pos_sum_x = {r_place_x[COORD_W-1], r_place_x} + {new_sx[COORD_W-1], new_sx};
    assign pos_sum_y = {r_place_y[COORD_W-1], r_place_y} + {new_sy[COORD_W-1], new_sy};
    assign new_px    = sat_pos(pos_sum_x);
    assign new_py    = sat_pos(pos_sum_y);

    // inside test of one trail point a cycle
    assign tr_x      = r_trail_x[r_idx];
    assign tr_y      = r_trail_y[r_idx];
    assign tr_inside = !tr_x[COORD_W-1] && (tr_x <= $signed(w_px)) &&
                       !tr_y[COORD_W-1] && (tr_y <= $signed(h_px));

    // wrap to the opposite edge
    always_comb begin
        wrap_px = r_place_x;
        wrap_py = r_place_y;
        if (r_place_x[COORD_W-1]) begin
            wrap_px = $signed(w_px);
        end else if (r_place_x > $signed(w_px)) begin
            wrap_px = '0;
        end
        if (r_place_y[COORD_W-1]) begin
            wrap_py = $signed(h_px);
        end else if (r_place_y > $signed(h_px)) begin
            wrap_py = '0;
        end
    end

    // operand selection for the shared units
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_den = r_root;
        unique case (r_state)
            S_SQX: begin
                mul_a = abs_ax;
                mul_b = abs_ax;
            end
            S_SQY: begin
                mul_a = abs_ay;
                mul_b = abs_ay;
            end
            S_FMUL: begin
                mul_a = {{(OPW-16){1'b0}}, r_strength};
                mul_b = {{(OPW-20){1'b0}}, r_radius - r_root[19:0]};
            end
            S_FDIV: begin
                div_den = {{(OPW-20){1'b0}}, r_radius};
            end
            S_PXM: begin
                mul_a = abs_ax;
                mul_b = {{(OPW-QW){1'b0}}, r_f};
            end
            S_PYM: begin
                mul_a = abs_ay;
                mul_b = {{(OPW-QW){1'b0}}, r_f};
            end
            S_VXM: begin
                mul_a = abs_ax;
                mul_b = {{(OPW-16){1'b0}}, r_limit};
            end
            S_VYM: begin
                mul_a = abs_ay;
                mul_b = {{(OPW-16){1'b0}}, r_limit};
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_kick  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (s_axis_tuser == OP_NEIGHBOR || s_axis_tuser == OP_TICK)) begin
                    n_state = S_SQX;
                    n_kick  = 1'b1;
                end
            end
            S_SQX: if (mul_done) begin
                n_state = S_SQY;
                n_kick  = 1'b1;
            end
            S_SQY: if (mul_done) begin
                n_state = S_ROOT;
                n_kick  = 1'b1;
            end
            S_ROOT: begin
                if (sq_done) begin
                    n_kick = 1'b1;
                    if (r_tick) begin
                        if (sq_root > {{(OPW-16){1'b0}}, r_limit}) begin
                            n_state = S_VXM;
                        end else begin
                            n_state = S_MOVE;
                            n_kick  = 1'b0;
                        end
                    end else if (sq_root == '0 ||
                                 sq_root >= {{(OPW-20){1'b0}}, r_radius}) begin
                        n_state = S_IDLE;
                        n_kick  = 1'b0;
                    end else begin
                        n_state = S_FMUL;
                    end
                end
            end
            S_FMUL: if (mul_done) begin
                n_state = S_FDIV;
                n_kick  = 1'b1;
            end
            S_FDIV: if (div_done) begin
                n_state = S_PXM;
                n_kick  = 1'b1;
            end
            S_PXM: if (mul_done) begin
                n_state = S_PXD;
                n_kick  = 1'b1;
            end
            S_PXD: if (div_done) begin
                n_state = S_PYM;
                n_kick  = 1'b1;
            end
            S_PYM: if (mul_done) begin
                n_state = S_PYD;
                n_kick  = 1'b1;
            end
            S_PYD: if (div_done) begin
                n_state = S_IDLE;
            end
            S_VXM: if (mul_done) begin
                n_state = S_VXD;
                n_kick  = 1'b1;
            end
            S_VXD: if (div_done) begin
                n_state = S_VYM;
                n_kick  = 1'b1;
            end
            S_VYM: if (mul_done) begin
                n_state = S_VYD;
                n_kick  = 1'b1;
            end
            S_VYD: if (div_done) begin
                n_state = S_MOVE;
            end
            S_MOVE: n_state = S_SCAN;
            S_SCAN: begin
                if (r_idx == IDX_W'(TRAIL_LEN - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= n_kick;
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 12'd1024;
            r_height   <= 12'd768;
            r_limit    <= 16'd1024;
            r_radius   <= 20'd12800;
            r_strength <= 16'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:    r_width    <= i_cfg_data[11:0];
                REG_HEIGHT:   r_height   <= i_cfg_data[11:0];
                REG_LIMIT:    r_limit    <= i_cfg_data[15:0];
                REG_RADIUS:   r_radius   <= i_cfg_data;
                REG_STRENGTH: r_strength <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place_x <= '0;
            r_place_y <= '0;
            r_speed_x <= '0;
            r_speed_y <= '0;
            r_push_x  <= '0;
            r_push_y  <= '0;
            for (int i = 0; i < TRAIL_LEN; i++) begin
                r_trail_x[i] <= '0;
                r_trail_y[i] <= '0;
            end
        end else begin
            // place request
            if (r_state == S_IDLE && in_accept && s_axis_tuser == OP_PLACE) begin
                r_place_x <= in_x;
                r_place_y <= in_y;
                r_speed_x <= '0;
                r_speed_y <= '0;
                r_push_x  <= '0;
                r_push_y  <= '0;
                for (int i = 0; i < TRAIL_LEN; i++) begin
                    r_trail_x[i] <= in_x;
                    r_trail_y[i] <= in_y;
                end
            end
            // repulsion accumulation
            if (r_state == S_PXD && div_done) begin
                r_push_x <= sat_push(push_sum_x);
            end
            if (r_state == S_PYD && div_done) begin
                r_push_y <= sat_push(push_sum_y);
            end
            // move and shift the trail
            if (r_state == S_MOVE) begin
                r_speed_x <= new_sx;
                r_speed_y <= new_sy;
                r_push_x  <= '0;
                r_push_y  <= '0;
                r_place_x <= new_px;
                r_place_y <= new_py;
                for (int i = TRAIL_LEN - 1; i > 0; i--) begin
                    r_trail_x[i] <= r_trail_x[i-1];
                    r_trail_y[i] <= r_trail_y[i-1];
                end
                r_trail_x[0] <= new_px;
                r_trail_y[0] <= new_py;
            end
            // wrap and refill when the whole trail left the screen
            if (r_state == S_EMIT && out_free && !r_inside) begin
                r_place_x <= wrap_px;
                r_place_y <= wrap_py;
                for (int i = 0; i < TRAIL_LEN; i++) begin
                    r_trail_x[i] <= wrap_px;
                    r_trail_y[i] <= wrap_py;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_accept) begin
            if (s_axis_tuser == OP_TICK) begin
                r_ax <= VEL_W'(r_speed_x) + VEL_W'(r_push_x);
                r_ay <= VEL_W'(r_speed_y) + VEL_W'(r_push_y);
            end else begin
                r_ax <= VEL_W'(r_place_x) - VEL_W'(in_x);
                r_ay <= VEL_W'(r_place_y) - VEL_W'(in_y);
            end
            r_tick <= (s_axis_tuser == OP_TICK);
        end
        if (r_state == S_SQX && mul_done) begin
            r_sq <= mul_prod;
        end
        if (r_state == S_SQY && mul_done) begin
            r_sq <= r_sq + mul_prod;
        end
        if (r_state == S_ROOT && sq_done) begin
            r_root <= sq_root;
        end
        if (r_state == S_FDIV && div_done) begin
            r_f <= div_quo;
        end
        if (r_state == S_VXD && div_done) begin
            r_ax <= q_signed_x;
        end
        if (r_state == S_VYD && div_done) begin
            r_ay <= q_signed_y;
        end
        if (r_state == S_MOVE) begin
            r_idx    <= '0;
            r_inside <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (tr_inside) begin
                r_inside <= 1'b1;
            end
            if (r_idx != IDX_W'(TRAIL_LEN - 1)) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_x    <= r_inside ? r_place_x : wrap_px;
            r_out_y    <= r_inside ? r_place_y : wrap_py;
            r_out_wrap <= !r_inside;
        end
    end

    pir_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick && (r_state == S_SQX || r_state == S_SQY || r_state == S_FMUL ||
                  r_state == S_PXM || r_state == S_PYM || r_state == S_VXM ||
                  r_state == S_VYM)),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pir_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick && r_state == S_ROOT),
        .i_n     (r_sq),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    pir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick && (r_state == S_FDIV || r_state == S_PXD || r_state == S_PYD ||
                  r_state == S_VXD || r_state == S_VYD)),
        .i_num   (mul_prod),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_wrap;

endmodule

// File: dv/tb_particle_integrator_with_repulsion_top.sv
`timescale 1ns / 100ps

import pir_pkg::*;

// one tick result as it leaves the block
typedef struct packed {
    logic        wrapped;
    logic [23:0] pos_y;
    logic [23:0] pos_x;
} tick_pos_t;

// tracks the particle and holds the tick positions still due
class particle_scoreboard;
    int unsigned scr_w, scr_h, vlimit, radius, strength;
    longint      px, py, vx, vy, ax, ay;
    longint      tx[TRAIL_LEN];
    longint      ty[TRAIL_LEN];
    tick_pos_t   due_pos[$];
    int          errors;

    function new();
        scr_w    = 1024;
        scr_h    = 768;
        vlimit   = 1024;
        radius   = 12800;
        strength = 128;
        px = 0; py = 0; vx = 0; vy = 0; ax = 0; ay = 0;
        foreach (tx[i]) begin
            tx[i] = 0;
            ty[i] = 0;
        end
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [19:0] val);
        case (idx)
            REG_WIDTH:    scr_w    = val[11:0];
            REG_HEIGHT:   scr_h    = val[11:0];
            REG_LIMIT:    vlimit   = val[15:0];
            REG_RADIUS:   radius   = val;
            REG_STRENGTH: strength = val[15:0];
            default: ;
        endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // integer square root, floor
    function longint unsigned isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // a * num / den, rounded toward zero
    function longint scale(longint a, longint unsigned num, longint unsigned den);
        longint unsigned mag, q;
        mag = (a < 0) ? -a : a;
        q = mag * num / den;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void refill();
        foreach (tx[i]) begin
            tx[i] = px;
            ty[i] = py;
        end
    endfunction

    function void note_request(logic [1:0] op, logic [23:0] cx, logic [23:0] cy);
        longint          dx, dy, w, h, nvx, nvy;
        longint unsigned d, f;
        bit              seen;
        tick_pos_t       r;
        case (op)
            OP_NEIGHBOR: begin
                dx = px - longint'($signed(cx));
                dy = py - longint'($signed(cy));
                d = isqrt(dx * dx + dy * dy);
                if (d != 0 && d < radius) begin
                    f = longint'(strength) * (radius - d) / radius;
                    ax = clamp(ax + scale(dx, f, d), -134217728, 134217727);
                    ay = clamp(ay + scale(dy, f, d), -134217728, 134217727);
                end
            end
            OP_TICK: begin
                nvx = vx + ax;
                nvy = vy + ay;
                d = isqrt(nvx * nvx + nvy * nvy);
                if (d > vlimit) begin
                    nvx = scale(nvx, vlimit, d);
                    nvy = scale(nvy, vlimit, d);
                end
                vx = clamp(nvx, -8388608, 8388607);
                vy = clamp(nvy, -8388608, 8388607);
                ax = 0;
                ay = 0;
                px = clamp(px + vx, -8388608, 8388607);
                py = clamp(py + vy, -8388608, 8388607);
                for (int i = TRAIL_LEN - 1; i > 0; i--) begin
                    tx[i] = tx[i-1];
                    ty[i] = ty[i-1];
                end
                tx[0] = px;
                ty[0] = py;
                w = longint'(scr_w) * 256;
                h = longint'(scr_h) * 256;
                seen = 0;
                foreach (tx[i])
                    if (tx[i] >= 0 && tx[i] <= w && ty[i] >= 0 && ty[i] <= h) seen = 1;
                r.wrapped = !seen;
                if (!seen) begin
                    if (px < 0) px = w;
                    else if (px > w) px = 0;
                    if (py < 0) py = h;
                    else if (py > h) py = 0;
                    refill();
                end
                r.pos_x = px[23:0];
                r.pos_y = py[23:0];
                due_pos.push_back(r);
            end
            OP_PLACE: begin
                px = longint'($signed(cx));
                py = longint'($signed(cy));
                vx = 0; vy = 0; ax = 0; ay = 0;
                refill();
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [47:0] data, logic [0:0] user);
        tick_pos_t e;
        if (due_pos.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h wrapped=%b",
                     $time, data[23:0], data[47:24], user[0]);
            errors++;
            return;
        end
        e = due_pos.pop_front();
        if (data[23:0] !== e.pos_x) begin
            $display("%0t: pos_x expected %h got %h", $time, e.pos_x, data[23:0]);
            errors++;
        end
        if (data[47:24] !== e.pos_y) begin
            $display("%0t: pos_y expected %h got %h", $time, e.pos_y, data[47:24]);
            errors++;
        end
        if (user[0] !== e.wrapped) begin
            $display("%0t: wrapped expected %b got %b", $time, e.wrapped, user[0]);
            errors++;
        end
    endfunction
endclass

module tb_particle_integrator_with_repulsion_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 400;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [19:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    particle_scoreboard sb = new();
    bit send_gaps = 1;
    bit recv_stalls = 1;
    int stall_left = 0;
    int quiet = 0;
    int sent = 0;

    particle_integrator_with_repulsion_top dut (.*);

    always #1 i_clk = ~i_clk;

    // result side: check, then draw a stall for the next result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser);
                stall_left = recv_stalls ? $urandom_range(0, 4) : 0;
            end
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(logic [1:0] op, longint cx, longint cy);
        int gap;
        gap = send_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {cy[23:0], cx[23:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(op, cx[23:0], cy[23:0]);
        sent++;
    endtask

    // let every due tick arrive and the block settle
    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.due_pos.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(int w, int h, int lim, int rad, int str);
        logic [19:0] v[5];
        v = '{20'(w), 20'(h), 20'(lim), 20'(rad), 20'(str)};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we   <= 1;
            i_cfg_idx  <= i[2:0];
            i_cfg_data <= v[i];
            @(posedge i_clk);
            sb.set_reg(i[2:0], v[i]);
        end
        i_cfg_we <= 0;
    endtask

    function automatic longint rand_coord();
        return longint'($signed(24'($urandom)));
    endfunction

    function automatic longint sat24(longint v);
        return (v < -8388608) ? -8388608 : ((v > 8388607) ? 8388607 : v);
    endfunction

    // one placed particle, then ticks, each after up to three neighbor or unused requests
    task automatic run_sequence();
        longint sx, sy, w, h, r, ox, oy;
        int ticks, k;
        w = longint'(sb.scr_w) * 256;
        h = longint'(sb.scr_h) * 256;
        case ($urandom_range(0, 3))
            0: begin sx = rand_coord(); sy = rand_coord(); end
            1: begin sx = $urandom_range(0, 4000); sy = longint'($urandom_range(0, h)); end
            2: begin sx = w - $urandom_range(0, 4000); sy = h - $urandom_range(0, 4000); end
            default: begin
                sx = longint'($urandom_range(0, w)); sy = longint'($urandom_range(0, h));
            end
        endcase
        send(OP_PLACE, sx, sy);
        ticks = $urandom_range(1, 24);
        for (int t = 0; t < ticks; t++) begin
            k = $urandom_range(0, 3);
            for (int n = 0; n < k; n++) begin
                r = (sb.radius > 0) ? sb.radius + 64 : 4096;
                ox = longint'($urandom_range(0, 2 * r)) - r;
                oy = longint'($urandom_range(0, 2 * r)) - r;
                case ($urandom_range(0, 9))
                    0: send(OP_NEIGHBOR, rand_coord(), rand_coord());
                    1: send(OP_NEIGHBOR, sb.px, sb.py);
                    2: send(OP_UNUSED, rand_coord(), rand_coord());
                    default: send(OP_NEIGHBOR, sat24(sb.px - ox), sat24(sb.py - oy));
                endcase
            end
            send(OP_TICK, rand_coord(), rand_coord());
        end
    endtask

    task automatic random_phase(int items);
        int start;
        start = sent;
        while (sent - start < items) begin
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            run_sequence();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset settings, extremes and corner requests
        send(OP_TICK, 0, 0);
        send(OP_PLACE, 8388607, -8388608);
        send(OP_NEIGHBOR, 8388607, -8388608);
        send(OP_NEIGHBOR, -8388608, 8388607);
        send(OP_TICK, -1, -1);
        send(OP_PLACE, 100 * 256, 100 * 256);
        send(OP_NEIGHBOR, 100 * 256, 100 * 256);
        send(OP_NEIGHBOR, 99 * 256, 100 * 256);
        send(OP_NEIGHBOR, 100 * 256, 101 * 256);
        send(OP_NEIGHBOR, 51 * 256, 100 * 256);
        send(OP_UNUSED, -1, -1);
        send(OP_TICK, 0, 0);
        send(OP_TICK, 0, 0);
        send(OP_PLACE, -256, 1024 * 256);
        send(OP_TICK, 0, 0);
        send(OP_PLACE, 1024 * 256 + 1, -1);
        send(OP_NEIGHBOR, 1024 * 256 + 2, 0);
        send(OP_TICK, 0, 0);
        drain();

        // wide repulsion, hard speed clamp
        write_regs(4095, 4095, 0, 1048575, 65535);
        send(OP_PLACE, 0, 0);
        send(OP_NEIGHBOR, 256, 256);
        send(OP_TICK, 0, 0);
        send(OP_PLACE, -8388608, 8388607);
        send(OP_NEIGHBOR, -8388608 + 300, 8388607 - 100);
        send(OP_TICK, 0, 0);
        random_phase(150);
        drain();

        // tiny screen, fast particles
        write_regs(1, 1, 65535, 200000, 65535);
        random_phase(150);
        drain();

        // zero radius, no push at all
        write_regs(640, 480, 2000, 0, 40000);
        random_phase(120);
        drain();

        // zero screen and zero strength
        write_regs(32'hFF000, 32'hFF000, 512, 5000, 0);
        random_phase(120);
        drain();

        // random settings
        for (int p = 0; p < 3; p++) begin
            write_regs($urandom_range(1, 4095), $urandom_range(1, 4095),
                       $urandom_range(0, 65535), $urandom_range(0, 1048575),
                       $urandom_range(0, 65535));
            random_phase(130);
            drain();
        end

        // reset settings again, register index past the last one
        write_regs(1024, 768, 1024, 12800, 128);
        i_cfg_we   <= 1;
        i_cfg_idx  <= 3'd7;
        i_cfg_data <= 20'hFFFFF;
        @(posedge i_clk);
        sb.set_reg(3'd7, 20'hFFFFF);
        i_cfg_we <= 0;
        random_phase(100);
        drain();

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
